[src/stq_pkg.sv]
// Shared codes, command and status types for the sorted timer queue.
package stq_pkg;

   localparam int TIMERS_DEF = 32;
   localparam int MAX_RES    = 32;

   // Request kinds
   localparam logic [2:0] KIND_ALLOC = 3'd0;
   localparam logic [2:0] KIND_FREE  = 3'd1;
   localparam logic [2:0] KIND_BIND  = 3'd2;
   localparam logic [2:0] KIND_ARM   = 3'd3;
   localparam logic [2:0] KIND_TICK  = 3'd4;

   // Response kinds
   localparam logic [1:0] RES_ALLOC  = 2'd0;
   localparam logic [1:0] RES_ACK    = 2'd1;
   localparam logic [1:0] RES_EXPIRY = 2'd2;
   localparam logic [1:0] RES_TASK   = 2'd3;

   // Slot states
   localparam logic [1:0] SLOT_FREE  = 2'd0;
   localparam logic [1:0] SLOT_ALLOC = 2'd1;
   localparam logic [1:0] SLOT_ARMED = 2'd2;

   localparam logic [31:0] DL_MAX = 32'hffff_ffff;

   typedef enum logic [4:0] {
      S_IDLE, S_A_SCAN, S_F_CHK, S_F_SET, S_B_WR, S_R_CHK,
      S_U0, S_U1, S_U_HD, S_U_WALK, S_U_END,
      S_I0, S_I1, S_I_T, S_I_C, S_I_W2,
      S_T_INC, S_E_CHK, S_E_LNK, S_E_DL, S_E_FIN, S_E_TS, S_ACK
   } state_type;

   typedef enum logic [2:0] {LA_SLOT, LA_HEAD, LA_LINK, LA_PTR, LA_NXT} lrd_sel_type;
   typedef enum logic [1:0] {LW_PTR_SUCC, LW_SLOT_HEAD, LW_PTR_SLOT, LW_SLOT_NXT} lwr_sel_type;
   typedef enum logic [2:0] {PTR_HOLD, PTR_ZERO, PTR_INC, PTR_HEAD, PTR_LINK, PTR_NXT}
      ptr_op_type;
   typedef enum logic [1:0] {HEAD_HOLD, HEAD_SLOT, HEAD_SUCC, HEAD_PTR} head_op_type;
   typedef enum logic [1:0] {ND_HOLD, ND_DNEW, ND_DL, ND_HDL} nd_op_type;
   typedef enum logic [1:0] {HDL_HOLD, HDL_NEXT, HDL_DL} hdl_op_type;
   typedef enum logic [1:0] {EM_ALLOC, EM_ACK, EM_PEND, EM_TASK} emit_sel_type;
   typedef enum logic {STA_SLOT, STA_PTR} st_addr_type;

   typedef struct packed {
      logic         load_item;
      logic         tick_inc;
      logic         dnew_load;
      lrd_sel_type  lrd_sel;
      logic         lw_en;
      lwr_sel_type  lw_sel;
      logic         dl_we;
      logic         msg_we;
      logic         st_we;
      st_addr_type  st_addr;
      logic [1:0]   st_val;
      ptr_op_type   ptr_op;
      head_op_type  head_op;
      nd_op_type    nd_op;
      hdl_op_type   hdl_op;
      logic         succ_load;
      logic         nxt_load;
      logic         exp_init;
      logic         exp_take;
      logic         pend_load;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_found;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       slot_ok;
      logic       slot_armed;
      logic       scan_free;
      logic       ptr_last;
      logic       head_is_slot;
      logic       link_is_slot;
      logic       link_zero;
      logic       dnew_le_next;
      logic       dnew_le_dl;
      logic       exp_go;
      logic       pend_v;
      logic       ts;
      logic       out_free;
   } status_type;

endpackage

[src/stq_ctrl.sv]
// Sequencer for the sorted timer queue: walks requests through the datapath.
module stq_ctrl
   import stq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_kind,
   input  status_type status,
   output cmd_type    cmd,
   output logic       idle
);

   state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cmd.ptr_op    = PTR_ZERO;
               priority case (req_kind)
                  KIND_ALLOC: state_in = S_A_SCAN;
                  KIND_FREE:  state_in = S_F_CHK;
                  KIND_BIND:  state_in = S_B_WR;
                  KIND_ARM:   state_in = S_R_CHK;
                  KIND_TICK:  state_in = S_T_INC;
                  default:    state_in = S_ACK;
               endcase
            end
         end
         S_A_SCAN: begin
            if (status.scan_free) begin
               if (status.out_free) begin
                  cmd.st_we      = 1'b1;
                  cmd.st_addr    = STA_PTR;
                  cmd.st_val     = SLOT_ALLOC;
                  cmd.emit       = 1'b1;
                  cmd.emit_sel   = EM_ALLOC;
                  cmd.emit_found = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (status.ptr_last) begin
               if (status.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = EM_ALLOC;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.ptr_op = PTR_INC;
            end
         end
         S_F_CHK: begin
            if (status.slot_ok) begin
               state_in = status.slot_armed ? S_U0 : S_F_SET;
            end else begin
               state_in = S_ACK;
            end
         end
         S_F_SET: begin
            cmd.st_we   = 1'b1;
            cmd.st_addr = STA_SLOT;
            cmd.st_val  = SLOT_FREE;
            state_in    = S_ACK;
         end
         S_B_WR: begin
            cmd.msg_we = status.slot_ok;
            state_in   = S_ACK;
         end
         S_R_CHK: begin
            if (status.slot_ok) begin
               state_in = status.slot_armed ? S_U0 : S_I0;
            end else begin
               state_in = S_ACK;
            end
         end
         // Unlink: fetch the successor, then splice it in
         S_U0: begin
            cmd.lrd_sel = LA_SLOT;
            state_in    = S_U1;
         end
         S_U1: begin
            cmd.succ_load = 1'b1;
            if (status.head_is_slot) begin
               state_in = S_U_HD;
            end else begin
               cmd.ptr_op  = PTR_HEAD;
               cmd.lrd_sel = LA_HEAD;
               state_in    = S_U_WALK;
            end
         end
         S_U_HD: begin
            cmd.head_op = HEAD_SUCC;
            cmd.nd_op   = ND_DL;
            state_in    = S_U_END;
         end
         S_U_WALK: begin
            if (status.link_is_slot) begin
               cmd.lw_en  = 1'b1;
               cmd.lw_sel = LW_PTR_SUCC;
               state_in   = S_U_END;
            end else if (status.link_zero) begin
               state_in = S_U_END;
            end else begin
               cmd.ptr_op  = PTR_LINK;
               cmd.lrd_sel = LA_LINK;
            end
         end
         S_U_END: begin
            state_in = (status.kind == KIND_FREE) ? S_F_SET : S_I0;
         end
         // Insert in deadline order
         S_I0: begin
            cmd.dnew_load = 1'b1;
            state_in      = S_I1;
         end
         S_I1: begin
            cmd.dl_we   = 1'b1;
            cmd.st_we   = 1'b1;
            cmd.st_addr = STA_SLOT;
            cmd.st_val  = SLOT_ARMED;
            if (status.dnew_le_next) begin
               cmd.lw_en   = 1'b1;
               cmd.lw_sel  = LW_SLOT_HEAD;
               cmd.head_op = HEAD_SLOT;
               cmd.nd_op   = ND_DNEW;
               state_in    = S_ACK;
            end else begin
               cmd.ptr_op  = PTR_HEAD;
               cmd.lrd_sel = LA_HEAD;
               state_in    = S_I_T;
            end
         end
         S_I_T: begin
            cmd.nxt_load = 1'b1;
            state_in     = S_I_C;
         end
         S_I_C: begin
            if (status.dnew_le_dl) begin
               cmd.lw_en  = 1'b1;
               cmd.lw_sel = LW_PTR_SLOT;
               state_in   = S_I_W2;
            end else begin
               cmd.ptr_op  = PTR_NXT;
               cmd.lrd_sel = LA_NXT;
               state_in    = S_I_T;
            end
         end
         S_I_W2: begin
            cmd.lw_en  = 1'b1;
            cmd.lw_sel = LW_SLOT_NXT;
            state_in   = S_ACK;
         end
         // Tick: advance count, expire leading slots
         S_T_INC: begin
            cmd.tick_inc = 1'b1;
            cmd.exp_init = 1'b1;
            cmd.ptr_op   = PTR_HEAD;
            cmd.hdl_op   = HDL_NEXT;
            state_in     = S_E_CHK;
         end
         S_E_CHK: begin
            if (status.exp_go) begin
               if (!status.pend_v || status.out_free) begin
                  cmd.emit     = status.pend_v;
                  cmd.emit_sel = EM_PEND;
                  cmd.exp_take = 1'b1;
                  cmd.st_we    = 1'b1;
                  cmd.st_addr  = STA_PTR;
                  cmd.st_val   = SLOT_ALLOC;
                  cmd.lrd_sel  = LA_PTR;
                  state_in     = S_E_LNK;
               end
            end else begin
               cmd.head_op = HEAD_PTR;
               cmd.nd_op   = ND_HDL;
               state_in    = S_E_FIN;
            end
         end
         S_E_LNK: begin
            cmd.pend_load = 1'b1;
            cmd.ptr_op    = PTR_LINK;
            state_in      = S_E_DL;
         end
         S_E_DL: begin
            cmd.hdl_op = HDL_DL;
            state_in   = S_E_CHK;
         end
         S_E_FIN: begin
            if (status.pend_v) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = EM_PEND;
                  cmd.emit_last = !status.ts;
                  state_in      = status.ts ? S_E_TS : S_IDLE;
               end
            end else begin
               state_in = status.ts ? S_E_TS : S_ACK;
            end
         end
         S_E_TS: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EM_TASK;
               state_in     = S_IDLE;
            end
         end
         S_ACK: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EM_ACK;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[src/stq_dp.sv]
// Datapath of the sorted timer queue: slot tables, list registers, response word.
module stq_dp
   import stq_pkg::*;
#(
   parameter int TIMERS = TIMERS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [2:0]  req_kind,
   input  logic [4:0]  req_slot,
   input  logic [3:0]  req_channel,
   input  logic [31:0] req_payload,
   input  logic [31:0] req_delay,
   input  logic        csr_we,
   input  logic [4:0]  csr_task_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [4:0]  rsp_slot_out,
   output logic        rsp_found,
   output logic [3:0]  rsp_channel_out,
   output logic [31:0] rsp_payload_out,
   output logic        rsp_last
);

   localparam int SW = $clog2(TIMERS);
   localparam int XW = SW + 5;
   localparam logic [SW-1:0] LAST_IDX = SW'(TIMERS - 1);

   // Item registers
   logic [2:0]    kind_ff;
   logic [SW-1:0] slot_ff;
   logic          slot_ok_ff;
   logic [3:0]    chan_ff;
   logic [31:0]   pay_ff;
   logic [31:0]   delay_ff;

   // List and count registers
   logic [4:0]    task_ff;
   logic [31:0]   tick_ff;
   logic [SW-1:0] head_ff;
   logic [31:0]   next_dl_ff;
   logic [1:0]    st_ff [TIMERS];
   logic [SW-1:0] ptr_ff, succ_ff, nxt_ff;
   logic [31:0]   hdl_ff, dnew_ff;
   logic [5:0]    cnt_ff;
   logic          ts_ff;
   logic          pend_v_ff;
   logic [SW-1:0] pend_slot_ff;
   logic [3:0]    pend_ch_ff;
   logic [31:0]   pend_pay_ff;

   // Slot tables
   logic [SW-1:0] link_mem [TIMERS];
   logic [31:0]   dl_mem   [TIMERS];
   logic [3:0]    ch_mem   [TIMERS];
   logic [31:0]   pay_mem  [TIMERS];
   logic [SW-1:0] link_rd_ff;
   logic [31:0]   dl_rd_ff;
   logic          dl_zero_ff;
   logic [3:0]    ch_rd_ff;
   logic [31:0]   pay_rd_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_kind_ff;
   logic [4:0]    rsp_slot_ff;
   logic          rsp_found_ff;
   logic [3:0]    rsp_ch_ff;
   logic [31:0]   rsp_pay_ff;
   logic          rsp_last_ff;

   logic [XW-1:0] req_slot_x, ptr_x, pend_x, task_x;
   logic [7:0]    req_slot8;
   logic          out_free;
   logic          ptr_is_task;
   logic [31:0]   dl_val;
   logic [SW-1:0] link_raddr, link_waddr, link_wdata;
   logic [SW-1:0] st_waddr;
   logic [1:0]    slot_st;

   assign req_slot_x  = XW'(req_slot);
   assign req_slot8   = 8'(req_slot);
   assign ptr_x       = XW'(ptr_ff);
   assign pend_x      = XW'(pend_slot_ff);
   assign task_x      = XW'(task_ff);
   assign ptr_is_task = (ptr_x == task_x);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign dl_val      = dl_zero_ff ? DL_MAX : dl_rd_ff;
   assign slot_st     = st_ff[slot_ff];

   // Capture the request word; bind accepts the sentinel slot as well
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff    <= req_kind;
         slot_ff    <= req_slot_x[SW-1:0];
         slot_ok_ff <= (req_slot8 < 8'(TIMERS)) &&
                       ((req_slot != 5'd0) || (req_kind == KIND_BIND));
         chan_ff    <= req_channel;
         pay_ff     <= req_payload;
         delay_ff   <= req_delay;
      end
   end

   // Task slot register
   always_ff @(posedge clock) begin
      if (reset) begin
         task_ff <= 5'd0;
      end else if (csr_we) begin
         task_ff <= csr_task_slot;
      end
   end

   // Link table port selection
   always_comb begin
      unique case (cmd.lrd_sel)
         LA_SLOT: link_raddr = slot_ff;
         LA_HEAD: link_raddr = head_ff;
         LA_LINK: link_raddr = link_rd_ff;
         LA_PTR:  link_raddr = ptr_ff;
         LA_NXT:  link_raddr = nxt_ff;
         default: link_raddr = slot_ff;
      endcase
      unique case (cmd.lw_sel)
         LW_PTR_SUCC:  begin link_waddr = ptr_ff;  link_wdata = succ_ff; end
         LW_SLOT_HEAD: begin link_waddr = slot_ff; link_wdata = head_ff; end
         LW_PTR_SLOT:  begin link_waddr = ptr_ff;  link_wdata = slot_ff; end
         LW_SLOT_NXT:  begin link_waddr = slot_ff; link_wdata = nxt_ff;  end
         default:      begin link_waddr = slot_ff; link_wdata = nxt_ff;  end
      endcase
   end

   // Slot tables, registered reads
   always_ff @(posedge clock) begin
      if (cmd.lw_en) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
      if (cmd.dl_we) begin
         dl_mem[slot_ff] <= dnew_ff;
      end
      dl_rd_ff   <= dl_mem[link_rd_ff];
      dl_zero_ff <= (link_rd_ff == '0);
      if (cmd.msg_we) begin
         ch_mem[slot_ff]  <= chan_ff;
         pay_mem[slot_ff] <= pay_ff;
      end
      ch_rd_ff  <= ch_mem[ptr_ff];
      pay_rd_ff <= pay_mem[ptr_ff];
   end

   assign st_waddr = (cmd.st_addr == STA_PTR) ? ptr_ff : slot_ff;

   // Slot states; the sentinel starts armed
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMERS; i++) begin
            st_ff[i] <= (i == 0) ? SLOT_ARMED : SLOT_FREE;
         end
      end else if (cmd.st_we) begin
         st_ff[st_waddr] <= cmd.st_val;
      end
   end

   // Tick count, head and head deadline
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= 32'd0;
         head_ff    <= '0;
         next_dl_ff <= DL_MAX;
      end else begin
         if (cmd.tick_inc) begin
            tick_ff <= tick_ff + 32'd1;
         end
         unique case (cmd.head_op)
            HEAD_HOLD: head_ff <= head_ff;
            HEAD_SLOT: head_ff <= slot_ff;
            HEAD_SUCC: head_ff <= succ_ff;
            HEAD_PTR:  head_ff <= ptr_ff;
            default:   head_ff <= head_ff;
         endcase
         unique case (cmd.nd_op)
            ND_HOLD: next_dl_ff <= next_dl_ff;
            ND_DNEW: next_dl_ff <= dnew_ff;
            ND_DL:   next_dl_ff <= dl_val;
            ND_HDL:  next_dl_ff <= hdl_ff;
            default: next_dl_ff <= next_dl_ff;
         endcase
      end
   end

   // Walk pointers and working deadlines
   always_ff @(posedge clock) begin
      unique case (cmd.ptr_op)
         PTR_HOLD: ptr_ff <= ptr_ff;
         PTR_ZERO: ptr_ff <= '0;
         PTR_INC:  ptr_ff <= ptr_ff + SW'(1);
         PTR_HEAD: ptr_ff <= head_ff;
         PTR_LINK: ptr_ff <= link_rd_ff;
         PTR_NXT:  ptr_ff <= nxt_ff;
         default:  ptr_ff <= ptr_ff;
      endcase
      if (cmd.succ_load) begin
         succ_ff <= link_rd_ff;
      end
      if (cmd.nxt_load) begin
         nxt_ff <= link_rd_ff;
      end
      if (cmd.dnew_load) begin
         dnew_ff <= tick_ff + delay_ff;
      end
      unique case (cmd.hdl_op)
         HDL_HOLD: hdl_ff <= hdl_ff;
         HDL_NEXT: hdl_ff <= next_dl_ff;
         HDL_DL:   hdl_ff <= dl_val;
         default:  hdl_ff <= hdl_ff;
      endcase
   end

   // Expiry bookkeeping: message count, task flag, held message
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 6'd0;
         ts_ff     <= 1'b0;
         pend_v_ff <= 1'b0;
      end else if (cmd.exp_init) begin
         cnt_ff    <= 6'd0;
         ts_ff     <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         if (cmd.exp_take) begin
            if (ptr_is_task) begin
               ts_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 6'd1;
            end
         end
         if (cmd.emit && cmd.emit_sel == EM_PEND) begin
            pend_v_ff <= 1'b0;
         end else if (cmd.pend_load && !ptr_is_task) begin
            pend_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_slot_ff <= ptr_ff;
         pend_ch_ff   <= ch_rd_ff;
         pend_pay_ff  <= pay_rd_ff;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff <= 1'b0;
         rsp_ch_ff    <= 4'd0;
         rsp_pay_ff   <= 32'd0;
         rsp_slot_ff  <= 5'd0;
         rsp_last_ff  <= 1'b1;
         unique case (cmd.emit_sel)
            EM_ALLOC: begin
               rsp_kind_ff  <= RES_ALLOC;
               rsp_found_ff <= cmd.emit_found;
               rsp_slot_ff  <= cmd.emit_found ? ptr_x[4:0] : 5'd0;
            end
            EM_ACK: begin
               rsp_kind_ff <= RES_ACK;
            end
            EM_PEND: begin
               rsp_kind_ff <= RES_EXPIRY;
               rsp_slot_ff <= pend_x[4:0];
               rsp_ch_ff   <= pend_ch_ff;
               rsp_pay_ff  <= pend_pay_ff;
               rsp_last_ff <= cmd.emit_last;
            end
            EM_TASK: begin
               rsp_kind_ff <= RES_TASK;
               rsp_slot_ff <= task_ff;
            end
            default: rsp_kind_ff <= RES_ACK;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_channel_out = rsp_ch_ff;
   assign rsp_payload_out = rsp_pay_ff;
   assign rsp_last        = rsp_last_ff;

   // Status back to the sequencer
   always_comb begin
      status.kind         = kind_ff;
      status.slot_ok      = slot_ok_ff;
      status.slot_armed   = (slot_st == SLOT_ARMED);
      status.scan_free    = (st_ff[ptr_ff] == SLOT_FREE);
      status.ptr_last     = (ptr_ff == LAST_IDX);
      status.head_is_slot = (head_ff == slot_ff);
      status.link_is_slot = (link_rd_ff == slot_ff);
      status.link_zero    = (link_rd_ff == '0);
      status.dnew_le_next = (dnew_ff <= next_dl_ff);
      status.dnew_le_dl   = (dnew_ff <= dl_val);
      status.exp_go       = (ptr_ff != '0) && ((cnt_ff + 6'(ts_ff)) < 6'(MAX_RES))
                            && (hdl_ff <= tick_ff);
      status.pend_v       = pend_v_ff;
      status.ts           = ts_ff;
      status.out_free     = out_free;
   end

endmodule

[src/sorted_timer_queue_top.sv]
// Top level of the sorted timer queue: sequencer plus datapath.
// Timer manager over TIMERS slots with a deadline-sorted list ending in the
// sentinel slot 0. One request word is taken at a time; the next is accepted
// once the last response of the current one sits in the response register.
// Allocate scans the slot states one per cycle; the sentinel slot 0 is never
// free. Free and arm of a listed slot first unlink it, at the head directly,
// else by walking the list entries ahead of it. Arm inserts at the head or
// elsewhere after walking the list entries passed, each step a link table
// read followed by a deadline table read. A tick expires leading slots and
// answers with expiry responses, a task switch request or a bare acknowledge,
// at most 32 responses per tick. Bind, a free or arm of the sentinel or of an
// out-of-range slot, and an unknown kind get an acknowledge alone. A response
// stall holds the sequencer until the response register is free.
module sorted_timer_queue_top
   import stq_pkg::*;
#(
   parameter int TIMERS = TIMERS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [4:0]  req_slot,
   input  logic [3:0]  req_channel,
   input  logic [31:0] req_payload,
   input  logic [31:0] req_delay,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [4:0]  rsp_slot_out,
   output logic        rsp_found,
   output logic [3:0]  rsp_channel_out,
   output logic [31:0] rsp_payload_out,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [4:0]  csr_task_slot
);

   cmd_type    cmd;
   status_type status;
   logic       idle;

   // Accept a word only while the sequencer waits
   assign req_stall = ~idle;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd),
      .idle      (idle)
   );

   stq_dp #(
      .TIMERS (TIMERS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_channel     (req_channel),
      .req_payload     (req_payload),
      .req_delay       (req_delay),
      .csr_we          (csr_we),
      .csr_task_slot   (csr_task_slot),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_found       (rsp_found),
      .rsp_channel_out (rsp_channel_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_last        (rsp_last)
   );

endmodule
